### rtl/egs_pkg.sv
// ----------------------------------------------------------------------------
// egs_pkg
// Types and constants shared by the epoch goodness scheduler and its parts.
// ----------------------------------------------------------------------------
package egs_pkg;

  // Operation codes of an input item.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RESCHED = 1'b1;

  // Process states.
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_CURRENT = 2'd2;
  localparam logic [1:0] ST_WAITING = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLLOVER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_Q   = 2'd1;

  localparam logic [15:0] ROLLOVER_RST = 16'd1;
  localparam logic [15:0] NULL_Q_RST   = 16'd10;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic        op;
    logic [4:0]  pid;
    logic [1:0]  proc_state;
    logic [7:0]  priority_req;
    logic [15:0] counter_value;
    logic [15:0] remaining_ticks;
  } egs_in_t;

  typedef struct packed {
    logic [4:0]  next_pid;
    logic [15:0] slice_ticks;
    logic        switched;
    logic        new_epoch;
  } egs_out_t;

  // One row of the process table.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [15:0] counter;
    logic        member;
    logic [7:0]  eprio;
  } egs_entry_t;

  localparam int unsigned ENTRY_W = $bits(egs_entry_t);

  // Contents of a row that has not been written since reset.
  function automatic egs_entry_t reset_entry(input logic is_pid0);
    egs_entry_t e;
    e         = '0;
    e.status  = is_pid0 ? ST_CURRENT : ST_FREE;
    e.member  = is_pid0;
    return e;
  endfunction

  function automatic logic runnable(input logic [1:0] st);
    return (st == ST_READY) || (st == ST_CURRENT);
  endfunction

endpackage

### rtl/egs_ram.sv
// ----------------------------------------------------------------------------
// egs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module egs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/epoch_goodness_scheduler.sv
// ----------------------------------------------------------------------------
// epoch_goodness_scheduler
// Goodness-based process selector with epoch rollover over a process table.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_stall    egs_in_t  (op, pid, state, ...)
//  out_      output     out_valid/out_stall  egs_out_t (next_pid, slice, ...)
//  cfg_      input      cfg_we               cfg_index, cfg_wdata
//
//  An entry write updates its row in S_WR_MOD (a pid beyond the table goes
//  straight to S_DONE); a reschedule credits the current row, scans the table,
//  makes a second table pass when a new epoch starts, then updates the winner
//  and, on a switch, the old process. Unwritten rows read as reset values via valid bits.
//  A result held by out_stall waits in the output register while the next item
//  is worked on; a second finished result then waits and stalls the input.
// ----------------------------------------------------------------------------
module epoch_goodness_scheduler
  import egs_pkg::*;
#(
  parameter int unsigned NUM_PROCS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  egs_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output egs_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam int unsigned PW = $clog2(NUM_PROCS);
  localparam int unsigned CW = PW + 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(NUM_PROCS);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_WR_MOD = 10'b00_0000_0010,
    S_CR_MOD = 10'b00_0000_0100,
    S_SCAN   = 10'b00_0000_1000,
    S_EPOCH  = 10'b00_0001_0000,
    S_GR_RD  = 10'b00_0010_0000,
    S_GR_WR  = 10'b00_0100_0000,
    S_PV_RD  = 10'b00_1000_0000,
    S_PV_WR  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } egs_state_t;

  egs_state_t           state_r, state_nxt;
  logic [PW-1:0]        cur_r, cur_nxt;
  logic [NUM_PROCS-1:0] valid_r;
  logic [15:0]          thr_r, nq_r;
  logic                 out_valid_r, out_valid_nxt;
  egs_out_t             out_data_r, out_data_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  egs_in_t              item_r, item_nxt;
  egs_out_t             res_r, res_nxt;
  logic [PW-1:0]        next_r, next_nxt;
  logic [16:0]          best_r, best_nxt;
  logic                 found_r, found_nxt;
  logic                 epoch_r, epoch_nxt;
  logic [PW-1:0]        raddr_r;
  logic                 rd_valid_r;

  logic                 ram_we;
  logic [PW-1:0]        ram_waddr, ram_raddr;
  egs_entry_t           ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  egs_entry_t           rd_entry;

  logic                 in_accept;
  logic                 pid_in_range;
  logic [PW-1:0]        in_pid_idx, item_pid_idx;
  logic [16:0]          credit_sum, good, half_sum;
  logic [15:0]          credit_sat, roll_cnt;
  logic                 take;
  logic                 out_free;
  logic                 sw;
  logic [15:0]          slice;

  egs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry  = rd_valid_r ? egs_entry_t'(ram_rdata) : reset_entry(raddr_r == '0);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign pid_in_range = (32'(in_data.pid) < NUM_PROCS);
  assign in_pid_idx   = PW'(in_data.pid);
  assign item_pid_idx = PW'(item_r.pid);

  // Credit of the unused ticks, saturating at the counter maximum.
  assign credit_sum = {1'b0, rd_entry.counter} + {1'b0, item_r.remaining_ticks};
  assign credit_sat = credit_sum[16] ? CNT_MAX : credit_sum[15:0];

  // Goodness of the row under scan.
  assign good = (rd_entry.counter == '0) ? 17'd0
              : ({1'b0, rd_entry.counter} + {9'd0, rd_entry.eprio});
  assign take = rd_entry.member &&
                (!found_r || (runnable(rd_entry.status) &&
                              ((good > best_r) || ((good == best_r) && (good != '0)))));

  // Epoch rollover of one counter.
  assign half_sum = {2'b00, rd_entry.counter[15:1]} + {9'd0, rd_entry.prio};
  assign roll_cnt = (rd_entry.counter >= thr_r)
                  ? (half_sum[16] ? CNT_MAX : half_sum[15:0])
                  : {8'd0, rd_entry.prio};

  assign sw    = (next_r != cur_r);
  assign slice = (next_r == '0) ? nq_r : rd_entry.counter;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    next_nxt      = next_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    epoch_nxt     = epoch_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = raddr_r;
    ram_wdata     = rd_entry;
    ram_raddr     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_nxt = in_data;
          if (in_data.op == OP_WRITE) begin
            if (pid_in_range) begin
              ram_raddr = in_pid_idx;
              state_nxt = S_WR_MOD;
            end else begin
              res_nxt   = '{next_pid: 5'(cur_r), slice_ticks: '0,
                            switched: 1'b0, new_epoch: 1'b0};
              state_nxt = S_DONE;
            end
          end else begin
            ram_raddr = cur_r;
            state_nxt = S_CR_MOD;
          end
        end
      end
      S_WR_MOD: begin
        ram_we            = 1'b1;
        ram_waddr         = item_pid_idx;
        ram_wdata.status  = item_r.proc_state;
        ram_wdata.prio    = item_r.priority_req;
        ram_wdata.counter = item_r.counter_value;
        res_nxt           = '{next_pid: 5'(cur_r), slice_ticks: '0,
                              switched: 1'b0, new_epoch: 1'b0};
        state_nxt         = S_DONE;
      end
      S_CR_MOD: begin
        ram_we            = 1'b1;
        ram_waddr         = cur_r;
        ram_wdata.counter = credit_sat;
        cnt_nxt           = '0;
        found_nxt         = 1'b0;
        best_nxt          = '0;
        next_nxt          = cur_r;
        epoch_nxt         = 1'b0;
        state_nxt         = S_SCAN;
      end
      S_SCAN: begin
        // Read of row cnt overlaps the evaluation of row cnt-1.
        if (cnt_r != LAST_CNT) begin
          ram_raddr = cnt_r[PW-1:0];
        end
        if (cnt_r != '0) begin
          if (rd_entry.member) begin
            found_nxt = 1'b1;
          end
          if (take) begin
            best_nxt = good;
            next_nxt = raddr_r;
          end
        end
        if (cnt_r == LAST_CNT) begin
          cnt_nxt = '0;
          if (best_nxt == '0) begin
            epoch_nxt = 1'b1;
            state_nxt = S_EPOCH;
          end else begin
            state_nxt = S_GR_RD;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EPOCH: begin
        if (cnt_r != LAST_CNT) begin
          ram_raddr = cnt_r[PW-1:0];
        end
        if (cnt_r != '0) begin
          ram_we           = 1'b1;
          ram_waddr        = raddr_r;
          ram_wdata.eprio  = rd_entry.prio;
          ram_wdata.member = runnable(rd_entry.status);
          if (rd_entry.status != ST_FREE) begin
            ram_wdata.counter = roll_cnt;
          end
        end
        if (cnt_r == LAST_CNT) begin
          state_nxt = S_GR_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GR_RD: begin
        ram_raddr = next_r;
        state_nxt = S_GR_WR;
      end
      S_GR_WR: begin
        ram_we            = 1'b1;
        ram_waddr         = next_r;
        ram_wdata.counter = '0;
        if (sw) begin
          ram_wdata.status = ST_CURRENT;
        end
        res_nxt   = '{next_pid: 5'(next_r), slice_ticks: slice,
                      switched: sw, new_epoch: epoch_r};
        state_nxt = sw ? S_PV_RD : S_DONE;
      end
      S_PV_RD: begin
        ram_raddr = cur_r;
        state_nxt = S_PV_WR;
      end
      S_PV_WR: begin
        if (rd_entry.status == ST_CURRENT) begin
          ram_we           = 1'b1;
          ram_waddr        = cur_r;
          ram_wdata.status = ST_READY;
        end
        cur_nxt   = next_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      valid_r     <= '0;
      thr_r       <= ROLLOVER_RST;
      nq_r        <= NULL_Q_RST;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROLLOVER: thr_r <= cfg_wdata;
          CFG_NULL_Q:   nq_r  <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    next_r     <= next_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    epoch_r    <= epoch_nxt;
    out_data_r <= out_data_nxt;
    raddr_r    <= ram_raddr;
    rd_valid_r <= valid_r[ram_raddr];
  end

  // A transfer always closes the input until the item is finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input accepted while an item was in progress");

  // A new epoch is only entered when the scan found no positive goodness.
  a_epoch_zero_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EPOCH) |-> (best_r == '0) && epoch_r)
    else $error("epoch pass with nonzero best goodness");

  // The old current process is only demoted on a real switch.
  a_switch_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PV_WR) |-> (next_r != cur_r))
    else $error("previous process touched without a switch");

  // The current pid always names a row of the table.
  a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_r) < NUM_PROCS)
    else $error("current pid outside the process table");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the epoch goodness scheduler. Items go in through
// the valid/stall input channel. A behavioral model of the process table
// predicts one outcome per accepted item. Each outcome is compared field by
// field with the result transfers, under random idling on both channels,
// several register settings and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import egs_pkg::*;

  localparam int NPROC          = 32;
  localparam int DRAIN_CYCLES   = 2 * NPROC + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTED    = 50;
  localparam int HOLD_CYCLES    = 600;

  // Indexes past the two implemented registers; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  egs_in_t              in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;
  logic                 in_stall;
  logic                 out_valid;
  egs_out_t             out_data;

  epoch_goodness_scheduler #(.NUM_PROCS(NPROC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Model of the process table and the registers.
  logic [1:0]  tbl_status [NPROC];
  logic [7:0]  tbl_prio   [NPROC];
  logic [15:0] tbl_count  [NPROC];
  bit          tbl_member [NPROC];
  logic [7:0]  tbl_eprio  [NPROC];
  logic [4:0]  running_pid;
  logic [15:0] carry_threshold;
  logic [15:0] idle_quantum;

  egs_out_t pending_outcomes[$];

  int error_count   = 0;
  int cycle_count   = 0;
  int hold_until    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_items       = 0;
  int n_resched     = 0;
  int n_epochs      = 0;
  int n_switches    = 0;
  int n_results     = 0;

  task automatic reset_model();
    for (int p = 0; p < NPROC; p++) begin
      tbl_status[p] = (p == 0) ? ST_CURRENT : ST_FREE;
      tbl_prio[p]   = '0;
      tbl_count[p]  = '0;
      tbl_member[p] = (p == 0);
      tbl_eprio[p]  = '0;
    end
    running_pid     = '0;
    carry_threshold = ROLLOVER_RST;
    idle_quantum    = NULL_Q_RST;
  endtask

  function automatic logic [15:0] clamp16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit can_run(input int p);
    return (tbl_status[p] == ST_READY) || (tbl_status[p] == ST_CURRENT);
  endfunction

  function automatic logic [16:0] goodness(input int p);
    if (tbl_count[p] == 16'd0) return 17'd0;
    return {1'b0, tbl_count[p]} + {9'd0, tbl_eprio[p]};
  endfunction

  // Counters of live processes roll over; membership and snapshots are rebuilt.
  function automatic void roll_epoch();
    logic [16:0] q;
    for (int p = 0; p < NPROC; p++) begin
      if (tbl_status[p] != ST_FREE) begin
        if (tbl_count[p] >= carry_threshold)
          q = {2'b00, tbl_count[p][15:1]} + {9'd0, tbl_prio[p]};
        else
          q = {9'd0, tbl_prio[p]};
        tbl_count[p] = clamp16(q);
      end
    end
    for (int p = 0; p < NPROC; p++) begin
      tbl_eprio[p]  = tbl_prio[p];
      tbl_member[p] = can_run(p);
    end
  endfunction

  function automatic egs_out_t predict_outcome(input egs_in_t item);
    egs_out_t    r;
    logic [4:0]  prev;
    logic [4:0]  winner;
    logic [16:0] best;
    logic [16:0] g;
    logic [15:0] slice;
    bit          found;
    r     = '0;
    found = 1'b0;
    if (item.op == OP_WRITE) begin
      tbl_status[item.pid] = item.proc_state;
      tbl_prio[item.pid]   = item.priority_req;
      tbl_count[item.pid]  = item.counter_value;
      r.next_pid = running_pid;
      return r;
    end
    n_resched++;
    prev = running_pid;
    tbl_count[prev] = clamp16({1'b0, tbl_count[prev]} + {1'b0, item.remaining_ticks});
    winner = prev;
    best   = '0;
    for (int p = 0; p < NPROC; p++) begin
      if (tbl_member[p]) begin
        if (!found) begin
          // The first member wins the slot whatever its state.
          found  = 1'b1;
          winner = p[4:0];
          best   = goodness(p);
        end else if (can_run(p)) begin
          g = goodness(p);
          if (g > best || (g == best && g != 0)) begin
            best   = g;
            winner = p[4:0];
          end
        end
      end
    end
    if (best == 0) begin
      roll_epoch();
      r.new_epoch = 1'b1;
      n_epochs++;
    end
    slice = tbl_count[winner];
    tbl_count[winner] = '0;
    if (winner == 5'd0) slice = idle_quantum;
    if (prev != winner) begin
      running_pid = winner;
      tbl_status[winner] = ST_CURRENT;
      if (tbl_status[prev] == ST_CURRENT) tbl_status[prev] = ST_READY;
      r.switched = 1'b1;
      n_switches++;
    end
    r.next_pid    = running_pid;
    r.slice_ticks = slice;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("ERROR at %0t: %s got %0d, want %0d", $time, what, got, want);
  endtask

  // Offers one item and waits for its transfer; the outcome is predicted then.
  task automatic send_item(input egs_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(item));
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_ROLLOVER) carry_threshold = val;
    else if (idx == CFG_NULL_Q) idle_quantum = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_count();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(16'hFFFF));
      2:       return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom_range(300));
    endcase
  endfunction

  function automatic egs_in_t random_item();
    egs_in_t it;
    it.op  = 1'($urandom_range(1));
    it.pid = 5'($urandom_range(NPROC - 1));
    case ($urandom_range(9))
      0:       it.proc_state = ST_FREE;
      1:       it.proc_state = ST_WAITING;
      2:       it.proc_state = ST_CURRENT;
      default: it.proc_state = ST_READY;
    endcase
    it.priority_req    = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(40));
    it.counter_value   = random_count();
    it.remaining_ticks = random_count();
    return it;
  endfunction

  function automatic egs_in_t entry_write(input logic [4:0] pid, input logic [1:0] st,
                                          input logic [7:0] prio, input logic [15:0] cnt);
    egs_in_t it;
    it               = random_item();
    it.op            = OP_WRITE;
    it.pid           = pid;
    it.proc_state    = st;
    it.priority_req  = prio;
    it.counter_value = cnt;
    return it;
  endfunction

  function automatic egs_in_t resched(input logic [15:0] ticks);
    egs_in_t it;
    it                 = random_item();
    it.op              = OP_RESCHED;
    it.remaining_ticks = ticks;
    return it;
  endfunction

  // Mostly a few entry writes followed by a reschedule, with some noise items.
  task automatic run_random(input int n_wanted);
    int sent;
    int burst;
    egs_in_t it;
    sent = 0;
    while (sent < n_wanted) begin
      if ($urandom_range(99) < 80) begin
        burst = $urandom_range(4);
        repeat (burst) begin
          it = random_item();
          it.op = OP_WRITE;
          send_item(it);
          sent++;
        end
        send_item(resched(random_count()));
        sent++;
      end else begin
        send_item(random_item());
        sent++;
      end
    end
  endtask

  // Extremes of the fields, writes to the running process, ties, empty epoch.
  task automatic test_reset_and_writes();
    send_idle_pct = 0;
    recv_idle_pct <= 30;
    send_item(resched(16'd0));
    send_item(entry_write(5'd31, ST_WAITING, 8'hFF, 16'hFFFF));
    send_item(entry_write(5'd31, ST_READY, 8'hFF, 16'hFFFF));
    send_item(entry_write(5'd1, ST_READY, 8'h00, 16'd1));
    send_item(resched(16'hFFFF));
    send_item(resched(16'd0));
    send_item(resched(16'd0));
    send_item(entry_write(5'd31, ST_WAITING, 8'd7, 16'd5));
    send_item(entry_write(5'd2, ST_FREE, 8'h80, 16'h8000));
    send_item(entry_write(5'd3, ST_WAITING, 8'd1, 16'd2));
    send_item(resched(16'd3));
    send_item(entry_write(5'd4, ST_READY, 8'd3, 16'd20));
    send_item(entry_write(5'd5, ST_READY, 8'd3, 16'd20));
    send_item(entry_write(5'd6, ST_CURRENT, 8'd0, 16'd0));
    send_item(resched(16'd0));
    send_item(resched(16'd0));
    send_item(resched(16'd0));
    // Park every live process so that the next epoch has no member at all.
    send_item(entry_write(5'd0, ST_WAITING, 8'd0, 16'd0));
    send_item(entry_write(5'd1, ST_FREE, 8'd0, 16'd0));
    send_item(entry_write(5'd4, ST_WAITING, 8'd2, 16'd0));
    send_item(entry_write(5'd5, ST_WAITING, 8'd2, 16'd0));
    send_item(entry_write(5'd6, ST_FREE, 8'd0, 16'd0));
    send_item(entry_write(5'd31, ST_WAITING, 8'd0, 16'd0));
    send_item(resched(16'd0));
    send_item(resched(16'd0));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    send_idle_pct = 20;
    recv_idle_pct <= 20;
    write_reg(CFG_ROLLOVER, 16'd0);
    write_reg(CFG_NULL_Q, 16'd0);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h1234);
    run_random(40);
    wait_drained();
    write_reg(CFG_ROLLOVER, 16'hFFFF);
    write_reg(CFG_NULL_Q, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'd0);
    run_random(40);
    wait_drained();
  endtask

  task automatic test_idle_mix();
    write_reg(CFG_ROLLOVER, 16'($urandom_range(1, 200)));
    write_reg(CFG_NULL_Q, 16'($urandom_range(1, 16'hFFFF)));
    send_idle_pct = 9;
    recv_idle_pct <= 62;
    run_random(450);
    wait_drained();
    write_reg(CFG_ROLLOVER, 16'($urandom_range(16'hFFFF)));
    write_reg(CFG_NULL_Q, 16'($urandom_range(1, 50)));
    send_idle_pct = 62;
    recv_idle_pct <= 9;
    run_random(450);
    wait_drained();
    write_reg(CFG_ROLLOVER, ROLLOVER_RST);
    write_reg(CFG_NULL_Q, NULL_Q_RST);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(450);
    wait_drained();
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 10;
    hold_until <= cycle_count + HOLD_CYCLES;
    run_random(40);
    wait_drained();
  endtask

  // The sender stops until every outstanding result has been seen.
  task automatic test_sender_pause();
    send_idle_pct = 5;
    recv_idle_pct <= 30;
    repeat (4) begin
      run_random(15);
      in_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clk);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin : result_check
    egs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result transfer with nothing pending, next_pid",
                        int'(out_data.next_pid), 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_data.next_pid !== want.next_pid)
          report_mismatch("next_pid", int'(out_data.next_pid), int'(want.next_pid));
        if (out_data.slice_ticks !== want.slice_ticks)
          report_mismatch("slice_ticks", int'(out_data.slice_ticks),
                          int'(want.slice_ticks));
        if (out_data.switched !== want.switched)
          report_mismatch("switched", int'(out_data.switched), int'(want.switched));
        if (out_data.new_epoch !== want.new_epoch)
          report_mismatch("new_epoch", int'(out_data.new_epoch), int'(want.new_epoch));
      end
      n_results++;
    end
    if (cycle_count < hold_until) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, pending_outcomes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_writes();
    test_register_extremes();
    test_idle_mix();
    test_backpressure();
    test_sender_pause();
    wait_drained();
    if (pending_outcomes.size() != 0)
      report_mismatch("results never delivered", 0, pending_outcomes.size());
    $display("Ran %0d items: %0d reschedules, %0d process switches, %0d epoch rollovers.",
             n_items, n_resched, n_switches, n_epochs);
    $display("Checked %0d results across several register settings and three idling mixes.",
             n_results);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
